/* rtl/trs_pkg.sv */
package trs_pkg;

	localparam int unsigned Alpha = 26;

	typedef logic [4:0] letter_t;
	typedef logic [2:0] wtype_t;

	typedef enum logic [1:0] {
		OP_STEP = 2'd0,
		OP_FWD  = 2'd1,
		OP_REV  = 2'd2,
		OP_LOAD = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_LEFT_TYPE   = 3'd0,
		CFG_MIDDLE_TYPE = 3'd1,
		CFG_RIGHT_TYPE  = 3'd2,
		CFG_LEFT_RING   = 3'd3,
		CFG_MIDDLE_RING = 3'd4,
		CFG_RIGHT_RING  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		letter_t l;
		letter_t m;
		letter_t r;
	} pos_t;

	typedef struct packed {
		wtype_t  wtype;
		letter_t ring;
	} rotor_cfg_t;

	typedef logic [7:0][25:0][4:0] wtab_t;

	// Published wirings of wheels I..VIII
	localparam logic [8*26-1:0] WireStr [8] = '{
		"EKMFLGDQVZNTOWYHXUSPAIBRCJ",
		"AJDKSIRUXBLHWTMCQGZNPYFVOE",
		"BDFHJLCPRTXVZNYEIWGAKMUSQO",
		"ESOVPZJAYQUIRHXLNFTGKDCMWB",
		"VZBRGITYUPSDNHLXAWMJQOFECK",
		"JPGVOUMFYQBENHZRDKASXLICTW",
		"NZJHGRCXMYSWBOUFAIVLPEKQDT",
		"FKQHTLXOCBJSPDZRAMEWNIUYGV"
	};

	function automatic wtab_t build_fwd();
		wtab_t     tab;
		logic [7:0] ch;
		tab = '0;
		for (int t = 0; t < 8; t++) begin
			for (int i = 0; i < Alpha; i++) begin
				ch = WireStr[t][8*(Alpha-1-i) +: 8] - 8'd65;
				tab[t][i] = ch[4:0];
			end
		end
		return tab;
	endfunction

	localparam wtab_t WireFwd = build_fwd();

	function automatic wtab_t build_inv();
		wtab_t tab;
		tab = '0;
		for (int t = 0; t < 8; t++) begin
			for (int i = 0; i < Alpha; i++) begin
				tab[t][WireFwd[t][i]] = 5'(i);
			end
		end
		return tab;
	endfunction

	localparam wtab_t WireInv = build_inv();

	// Reduce any 5-bit code into 0..25
	function automatic letter_t red26(input letter_t a);
		return (a >= 5'd26) ? 5'(a - 5'd26) : a;
	endfunction

	function automatic letter_t add26(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 6'd26) ? 5'(s - 6'd26) : s[4:0];
	endfunction

	function automatic letter_t sub26(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + 6'd26 - {1'b0, b});
		return s[4:0];
	endfunction

	function automatic logic at_notch(input wtype_t t, input letter_t p);
		logic hit;
		case (t)
			3'd0:    hit = (p == 5'd16);
			3'd1:    hit = (p == 5'd4);
			3'd2:    hit = (p == 5'd21);
			3'd3:    hit = (p == 5'd9);
			3'd4:    hit = (p == 5'd25);
			default: hit = (p == 5'd12) || (p == 5'd25);
		endcase
		return hit;
	endfunction

endpackage

/* rtl/trs_pass.sv */
// One rotor pass: y = tbl[x + d] - d, d = position - ring (mod 26)
module trs_pass (
	input  logic              rev,
	input  trs_pkg::wtype_t   wtype,
	input  trs_pkg::letter_t  d,
	input  trs_pkg::letter_t  x,
	output trs_pkg::letter_t  y
);

	trs_pkg::letter_t idx;
	trs_pkg::letter_t w;

	always_comb begin
		idx = trs_pkg::add26(x, d);
		w   = rev ? trs_pkg::WireInv[wtype][idx] : trs_pkg::WireFwd[wtype][idx];
		y   = trs_pkg::sub26(w, d);
	end

endmodule

/* rtl/trs_step.sv */
// Rotor stepping with double step of the middle rotor
module trs_step (
	input  trs_pkg::pos_t    pos,
	input  trs_pkg::wtype_t  middle_type,
	input  trs_pkg::wtype_t  right_type,
	output trs_pkg::pos_t    next
);

	logic mid_notch;
	logic right_notch;

	always_comb begin
		mid_notch   = trs_pkg::at_notch(middle_type, pos.m);
		right_notch = trs_pkg::at_notch(right_type, pos.r);
		next.l = mid_notch ? trs_pkg::add26(pos.l, 5'd1) : pos.l;
		next.m = (mid_notch || right_notch) ? trs_pkg::add26(pos.m, 5'd1) : pos.m;
		next.r = trs_pkg::add26(pos.r, 5'd1);
	end

endmodule

/* rtl/three_rotor_scrambler.sv */
// A request is accepted into the input register and then moves into the result register, where m_tvalid shows it.
// Throughput: one request per cycle while the output is not stalled; rotor mapping and stepping are combinational.
// With a result stalled at the output, the input register takes one more request, then holds.
// Reset (arst_n low, asynchronous): rotor positions to 0, wheel types to I, II, III,
// ring settings to 0, both pipeline stages emptied.
module three_rotor_scrambler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // letter_in[4:0], load_left[9:5], load_middle[14:10],
	                              // load_right[19:15], zero fill
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // letter_out[4:0], left_pos_out[9:5],
	                              // middle_pos_out[14:10], right_pos_out[19:15], zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	// Configuration registers
	trs_pkg::rotor_cfg_t cfg_l_q, cfg_m_q, cfg_r_q;

	// Rotor positions, always held in 0..25
	trs_pkg::pos_t pos_q;

	// Input stage
	logic              valid_s1;
	trs_pkg::op_t      op_s1;
	trs_pkg::letter_t  letter_s1;
	trs_pkg::pos_t     load_s1;

	// Result stage
	logic              valid_s2;
	trs_pkg::letter_t  letter_s2;
	trs_pkg::pos_t     pos_s2;

	logic              adv;

	// Move the held request into the result register when that register is free or drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Configuration writes; indexes past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_l_q <= '{wtype: 3'd0, ring: 5'd0};
			cfg_m_q <= '{wtype: 3'd1, ring: 5'd0};
			cfg_r_q <= '{wtype: 3'd2, ring: 5'd0};
		end else if (cfg_we) begin
			case (trs_pkg::cfg_idx_t'(cfg_index))
				trs_pkg::CFG_LEFT_TYPE:   cfg_l_q.wtype <= cfg_data[2:0];
				trs_pkg::CFG_MIDDLE_TYPE: cfg_m_q.wtype <= cfg_data[2:0];
				trs_pkg::CFG_RIGHT_TYPE:  cfg_r_q.wtype <= cfg_data[2:0];
				trs_pkg::CFG_LEFT_RING:   cfg_l_q.ring  <= cfg_data;
				trs_pkg::CFG_MIDDLE_RING: cfg_m_q.ring  <= cfg_data;
				trs_pkg::CFG_RIGHT_RING:  cfg_r_q.ring  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register: payload, reduced into the letter range on the way in
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= trs_pkg::op_t'(s_tuser);
			letter_s1 <= trs_pkg::red26(s_tdata[4:0]);
			load_s1.l <= trs_pkg::red26(s_tdata[9:5]);
			load_s1.m <= trs_pkg::red26(s_tdata[14:10]);
			load_s1.r <= trs_pkg::red26(s_tdata[19:15]);
		end
	end

	// Offset of each rotor: position minus ring setting, mod 26
	trs_pkg::letter_t d_l, d_m, d_r;
	assign d_l = trs_pkg::sub26(pos_q.l, trs_pkg::red26(cfg_l_q.ring));
	assign d_m = trs_pkg::sub26(pos_q.m, trs_pkg::red26(cfg_m_q.ring));
	assign d_r = trs_pkg::sub26(pos_q.r, trs_pkg::red26(cfg_r_q.ring));

	// Three passes in a chain; forward goes right, middle, left with the wiring,
	// reverse goes left, middle, right with the inverse wiring
	logic              rev;
	trs_pkg::wtype_t   t0, t2;
	trs_pkg::letter_t  o0, o2;
	trs_pkg::letter_t  x1, x2, x3;

	assign rev = (op_s1 == trs_pkg::OP_REV);
	assign t0  = rev ? cfg_l_q.wtype : cfg_r_q.wtype;
	assign o0  = rev ? d_l : d_r;
	assign t2  = rev ? cfg_r_q.wtype : cfg_l_q.wtype;
	assign o2  = rev ? d_r : d_l;

	trs_pass u_pass0 (.rev(rev), .wtype(t0),            .d(o0),  .x(letter_s1), .y(x1));
	trs_pass u_pass1 (.rev(rev), .wtype(cfg_m_q.wtype), .d(d_m), .x(x1),        .y(x2));
	trs_pass u_pass2 (.rev(rev), .wtype(t2),            .d(o2),  .x(x2),        .y(x3));

	// Stepping
	trs_pkg::pos_t stepped;

	trs_step u_step (
		.pos         (pos_q),
		.middle_type (cfg_m_q.wtype),
		.right_type  (cfg_r_q.wtype),
		.next        (stepped)
	);

	// Next positions and letter for the request in the input stage
	trs_pkg::pos_t    pos_nxt;
	trs_pkg::letter_t letter_nxt;

	always_comb begin
		pos_nxt    = pos_q;
		letter_nxt = '0;
		case (op_s1)
			trs_pkg::OP_STEP: pos_nxt    = stepped;
			trs_pkg::OP_FWD:  letter_nxt = x3;
			trs_pkg::OP_REV:  letter_nxt = x3;
			trs_pkg::OP_LOAD: pos_nxt    = load_s1;
			default:          pos_nxt    = pos_q;
		endcase
	end

	// Positions advance only as a request leaves the input stage, so requests see them in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (adv) begin
			pos_q <= pos_nxt;
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (adv) begin
			letter_s2 <= letter_nxt;
			pos_s2    <= pos_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, pos_s2.r, pos_s2.m, pos_s2.l, letter_s2};

	// Positions never leave the letter range
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q.l < 5'd26 && pos_q.m < 5'd26 && pos_q.r < 5'd26)
		else $error("rotor position out of range");

	// A step always advances the right rotor by one
	a_right_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == trs_pkg::OP_STEP |=>
		pos_q.r == (($past(pos_q.r) == 5'd25) ? 5'd0 : $past(pos_q.r) + 5'd1))
		else $error("right rotor did not step");

	// Step and load requests give a zero letter
	a_zero_letter: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (op_s1 == trs_pkg::OP_STEP || op_s1 == trs_pkg::OP_LOAD) |=>
		m_tdata[4:0] == 5'd0)
		else $error("letter not cleared for step or load");

	// A stalled result holds the input stage and the positions
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |=> valid_s1 && $stable(pos_q))
		else $error("input stage lost during output stall");

endmodule
